/* hdl/sequence_reorder_release_defines.svh */
// Assertion helpers, clocked on clk and quiet while rst_n is low.
`ifndef SEQUENCE_REORDER_RELEASE_DEFINES_SVH
`define SEQUENCE_REORDER_RELEASE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SRR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SRR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/srr_pkg.sv */
package srr_pkg;

    localparam int WINDOW = 32;
    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW) + 1;

    localparam logic [1:0] MODE_FULL  = 2'd0;
    localparam logic [1:0] MODE_EMPTY = 2'd1;
    localparam logic [1:0] MODE_EOF   = 2'd2;
    localparam logic [1:0] MODE_STOP  = 2'd3;

    localparam logic [1:0] STAT_ACCEPT      = 2'd0;
    localparam logic [1:0] STAT_WAIT        = 2'd1;
    localparam logic [1:0] STAT_DROP_OLD    = 2'd2;
    localparam logic [1:0] STAT_DROP_WINDOW = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_SCAN,
        ST_COUNT,
        ST_FINISH,
        ST_READ,
        ST_RELEASE,
        ST_SINGLE
    } state_t;

    // Population count as a small tree: groups of eight, then a sum of groups.
    function automatic logic [CNT_W-1:0] popcount(input logic [WINDOW-1:0] v);
        logic [CNT_W-1:0] total;
        logic [3:0]       group_sum;
        total = '0;
        for (int g = 0; g < (WINDOW + 7) / 8; g++)
        begin
            group_sum = '0;
            for (int b = 0; b < 8; b++)
            begin
                if (g * 8 + b < WINDOW)
                begin
                    group_sum = group_sum + 4'(v[g * 8 + b]);
                end
            end
            total = total + CNT_W'(group_sum);
        end
        return total;
    endfunction

endpackage

/* hdl/sequence_reorder_release.sv */
// Resequencer: slices offered out of order come out in strict index order from 0.
// Input channel (in_valid / in_stall): mode, slice_index, payload_handle,
// final_index, total_full. One word is taken when in_valid is high and in_stall low.
// Output channel (out_valid / out_stall): one word per released slice, in index
// order, or a single word with released low when nothing leaves; last marks the
// final word caused by an input, finish gives the completion flag after it.
// Steps: an input is classified and its slot written in ST_CLASSIFY, then ST_SCAN
// rotates the ring, ST_COUNT counts the ready run and ST_FINISH settles finish.
// Each released slice then passes ST_READ (handle RAM read) and ST_RELEASE
// (output load), which waits while the output register is stalled. An input
// that releases nothing, a stop and an input after finish each end in ST_SINGLE.
// Inputs are taken one at a time; the next is taken while the last word of the
// previous one still sits in the output register.
// Reset: the ring, counters, end state and completion flag clear at once; the
// handle RAM is not cleared, as a slot is only read once its valid mark is set.
// Stall: the block holds its current word and waits; nothing is lost.
module sequence_reorder_release (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [31:0] slice_index,
    input  logic [15:0] payload_handle,
    input  logic [31:0] final_index,
    input  logic [31:0] total_full,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        released,
    output logic [31:0] out_index,
    output logic [15:0] out_handle,
    output logic        is_empty,
    output logic [1:0]  status,
    output logic        finish,
    output logic        last
);
    import srr_pkg::*;

    `include "sequence_reorder_release_defines.svh"

    state_t state_reg, state_next;

    // latched input word
    logic [1:0]  mode_reg;
    logic [31:0] idx_reg;
    logic [15:0] handle_reg;
    logic [31:0] final_reg;
    logic [31:0] total_reg;
    logic        ignore_reg, ignore_next;

    // run state
    logic [31:0]       next_expected_reg, next_expected_next;
    logic [31:0]       full_released_reg, full_released_next;
    logic              end_seen_reg, end_seen_next;
    logic [31:0]       end_index_reg, end_index_next;
    logic [31:0]       end_total_reg, end_total_next;
    logic              done_reg, done_next;
    logic [WINDOW-1:0] valid_reg, valid_next;
    logic [WINDOW-1:0] empty_reg, empty_next;
    logic [1:0]        status_reg, status_next;

    // drain bookkeeping
    logic [WINDOW-1:0] rot_valid_reg, rot_valid_next;
    logic [WINDOW-1:0] rot_empty_reg, rot_empty_next;
    logic [CNT_W-1:0]  run_reg, run_next;
    logic [CNT_W-1:0]  fulls_reg, fulls_next;
    logic [CNT_W-1:0]  left_reg, left_next;

    // handle RAM
    logic [15:0] slot_handle_mem [WINDOW];
    logic [15:0] rd_data_reg;
    logic        mem_we;
    logic [15:0] mem_wdata;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic        released_reg, released_next;
    logic [31:0] out_index_reg, out_index_next;
    logic [15:0] out_handle_reg, out_handle_next;
    logic        is_empty_reg, is_empty_next;
    logic [1:0]  status_out_reg, status_out_next;
    logic        finish_reg, finish_next;
    logic        last_reg, last_next;

    logic              in_take;
    logic              out_free;
    logic [31:0]       diff;
    logic [SLOT_W-1:0] in_slot;
    logic [SLOT_W-1:0] ne_slot;
    logic [WINDOW-1:0] run_mask;
    logic [CNT_W-1:0]  run_count;
    logic [WINDOW-1:0] low_mask;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign diff      = idx_reg - next_expected_reg;
    assign in_slot   = idx_reg[SLOT_W-1:0];
    assign ne_slot   = next_expected_reg[SLOT_W-1:0];

    assign out_valid  = out_valid_reg;
    assign released   = released_reg;
    assign out_index  = out_index_reg;
    assign out_handle = out_handle_reg;
    assign is_empty   = is_empty_reg;
    assign status     = status_out_reg;
    assign finish     = finish_reg;
    assign last       = last_reg;

    // Ready run from the head of the rotated ring, and its length.
    always_comb
    begin
        run_count = CNT_W'(WINDOW);
        for (int i = 0; i < WINDOW; i++)
        begin
            low_mask    = {WINDOW{1'b1}} >> (WINDOW - 1 - i);
            run_mask[i] = &(rot_valid_reg | ~low_mask);
        end
        for (int i = 0; i < WINDOW; i++)
        begin
            if (!rot_valid_reg[i] && ((i == 0) || run_mask[(i == 0) ? 0 : i - 1]))
            begin
                run_count = CNT_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            ignore_reg        <= 1'b0;
            next_expected_reg <= '0;
            full_released_reg <= '0;
            end_seen_reg      <= 1'b0;
            end_index_reg     <= '0;
            end_total_reg     <= '0;
            done_reg          <= 1'b0;
            valid_reg         <= '0;
            empty_reg         <= '0;
            status_reg        <= STAT_ACCEPT;
            left_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            ignore_reg        <= ignore_next;
            next_expected_reg <= next_expected_next;
            full_released_reg <= full_released_next;
            end_seen_reg      <= end_seen_next;
            end_index_reg     <= end_index_next;
            end_total_reg     <= end_total_next;
            done_reg          <= done_next;
            valid_reg         <= valid_next;
            empty_reg         <= empty_next;
            status_reg        <= status_next;
            left_reg          <= left_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mode_reg   <= mode;
            idx_reg    <= slice_index;
            handle_reg <= payload_handle;
            final_reg  <= final_index;
            total_reg  <= total_full;
        end
        rot_valid_reg   <= rot_valid_next;
        rot_empty_reg   <= rot_empty_next;
        run_reg         <= run_next;
        fulls_reg       <= fulls_next;
        released_reg    <= released_next;
        out_index_reg   <= out_index_next;
        out_handle_reg  <= out_handle_next;
        is_empty_reg    <= is_empty_next;
        status_out_reg  <= status_out_next;
        finish_reg      <= finish_next;
        last_reg        <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_handle_mem[in_slot] <= mem_wdata;
        end
        rd_data_reg <= slot_handle_mem[ne_slot];
    end

    always_comb
    begin
        state_next         = state_reg;
        ignore_next        = ignore_reg;
        next_expected_next = next_expected_reg;
        full_released_next = full_released_reg;
        end_seen_next      = end_seen_reg;
        end_index_next     = end_index_reg;
        end_total_next     = end_total_reg;
        done_next          = done_reg;
        valid_next         = valid_reg;
        empty_next         = empty_reg;
        status_next        = status_reg;
        left_next          = left_reg;
        rot_valid_next     = rot_valid_reg;
        rot_empty_next     = rot_empty_reg;
        run_next           = run_reg;
        fulls_next         = fulls_reg;
        mem_we             = 1'b0;
        mem_wdata          = (mode_reg == MODE_FULL) ? handle_reg : 16'd0;

        out_valid_next  = out_valid_reg && out_stall;
        released_next   = released_reg;
        out_index_next  = out_index_reg;
        out_handle_next = out_handle_reg;
        is_empty_next   = is_empty_reg;
        status_out_next = status_out_reg;
        finish_next     = finish_reg;
        last_next       = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    ignore_next = done_reg;
                    status_next = done_reg ? STAT_DROP_OLD : STAT_ACCEPT;
                    state_next  = done_reg ? ST_SINGLE : ST_CLASSIFY;
                end
            end

            ST_CLASSIFY:
            begin
                case (mode_reg)
                    MODE_STOP:
                    begin
                        done_next  = 1'b1;
                        state_next = ST_SINGLE;
                    end
                    MODE_EOF:
                    begin
                        end_seen_next  = 1'b1;
                        end_index_next = final_reg;
                        end_total_next = total_reg;
                        state_next     = ST_SCAN;
                    end
                    default:
                    begin
                        state_next = ST_SCAN;
                        if (idx_reg < next_expected_reg)
                        begin
                            status_next = STAT_DROP_OLD;
                        end
                        else if (diff[31:SLOT_W] != '0)
                        begin
                            status_next = STAT_DROP_WINDOW;
                        end
                        else if (valid_reg[in_slot])
                        begin
                            status_next = STAT_DROP_OLD;
                        end
                        else
                        begin
                            valid_next[in_slot] = 1'b1;
                            empty_next[in_slot] = (mode_reg == MODE_EMPTY);
                            mem_we              = 1'b1;
                            status_next = (diff == '0) ? STAT_ACCEPT : STAT_WAIT;
                        end
                    end
                endcase
            end

            ST_SCAN:
            begin
                // bring the head slot to bit 0
                rot_valid_next = WINDOW'({valid_reg, valid_reg} >> ne_slot);
                rot_empty_next = WINDOW'({empty_reg, empty_reg} >> ne_slot);
                state_next     = ST_COUNT;
            end

            ST_COUNT:
            begin
                run_next   = run_count;
                fulls_next = popcount(run_mask & ~rot_empty_reg);
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                // finish is known before the first word of the drain leaves
                done_next = end_seen_reg
                    && ((next_expected_reg + 32'(run_reg)) == (end_index_reg + 32'd1))
                    && ((full_released_reg + 32'(fulls_reg)) == end_total_reg);
                left_next  = run_reg;
                state_next = (run_reg == '0) ? ST_SINGLE : ST_READ;
            end

            ST_READ:
            begin
                state_next = ST_RELEASE;
            end

            ST_RELEASE:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    released_next       = 1'b1;
                    out_index_next      = next_expected_reg;
                    out_handle_next     = empty_reg[ne_slot] ? 16'd0 : rd_data_reg;
                    is_empty_next       = empty_reg[ne_slot];
                    status_out_next     = status_reg;
                    finish_next         = done_reg;
                    last_next           = (left_reg == CNT_W'(1));
                    valid_next[ne_slot] = 1'b0;
                    next_expected_next  = next_expected_reg + 32'd1;
                    if (!empty_reg[ne_slot])
                    begin
                        full_released_next = full_released_reg + 32'd1;
                    end
                    left_next  = left_reg - CNT_W'(1);
                    state_next = (left_reg == CNT_W'(1)) ? ST_IDLE : ST_READ;
                end
            end

            ST_SINGLE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    released_next   = 1'b0;
                    out_index_next  = (!ignore_reg && (mode_reg inside {MODE_FULL, MODE_EMPTY}))
                                      ? idx_reg : 32'd0;
                    out_handle_next = 16'd0;
                    is_empty_next   = 1'b0;
                    status_out_next = status_reg;
                    finish_next     = done_reg;
                    last_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `SRR_ASSERT_NEXT(a_done_sticks, done_reg, done_reg, "finish flag cleared after completion")
    `SRR_ASSERT_NOW(a_run_bounded, state_reg == ST_FINISH, run_reg <= CNT_W'(WINDOW),
        "ready run longer than the ring")
    `SRR_ASSERT_NOW(a_release_valid, state_reg == ST_RELEASE, valid_reg[ne_slot],
        "releasing a slot with no entry")
    `SRR_ASSERT_NEXT(a_release_step, state_reg == ST_RELEASE && out_free,
        next_expected_reg == $past(next_expected_reg) + 32'd1,
        "head index did not advance on release")

endmodule
